[rtl/bil_pkg.sv]
// ----------------------------------------------------------------------------
// bil_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// bounded indexed list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bil_pkg;

  // List geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OP_W     = 3;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_END = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch a new transaction and decode it
    logic step;     // shift step: read one entry, write back the previous
    logic place;    // write the new value into its slot
    logic finish;   // update the count and load the result register
  } bil_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic shift_done;   // no reads left and no write in flight
    logic place_needed; // append or insert that passed its checks
  } bil_sts_t;

endpackage

`default_nettype wire

[rtl/bil_datapath.sv]
// ----------------------------------------------------------------------------
// bil_datapath
// Entry memory, count register, shift address counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bil_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bil_pkg::bil_cmd_t           cmd_i,
  output bil_pkg::bil_sts_t                sts_o,
  input  wire logic [bil_pkg::OP_W-1:0]    opcode_i,
  input  wire logic [bil_pkg::CNT_W-1:0]   position_i,
  input  wire logic [bil_pkg::VAL_W-1:0]   value_in_i,
  output logic                             status_o,
  output logic [bil_pkg::VAL_W-1:0]        value_out_o,
  output logic [bil_pkg::CNT_W-1:0]        count_o
);

  localparam logic [bil_pkg::CNT_W-1:0] Cap = bil_pkg::CNT_W'(bil_pkg::CAPACITY);

  // Entry memory, single write port and registered read
  logic [bil_pkg::VAL_W-1:0] mem [bil_pkg::CAPACITY];
  logic [bil_pkg::VAL_W-1:0] rdata_q;

  // Count of held entries (control state)
  logic [bil_pkg::CNT_W-1:0] held_q, held_d;

  // Transaction context
  logic                      err_q, err_d;
  logic                      is_ins_q, is_ins_d;     // shift direction up
  logic                      is_rem_q, is_rem_d;     // remove of any kind
  logic                      place_q, place_d;
  logic                      clr_q, clr_d;
  logic [bil_pkg::IDX_W-1:0] slot_q, slot_d;
  logic [bil_pkg::VAL_W-1:0] val_q;
  logic [bil_pkg::VAL_W-1:0] taken_q;

  // Shift engine
  logic [bil_pkg::IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [bil_pkg::CNT_W-1:0] rd_left_q, rd_left_d;
  logic                      rd_vld_q;
  logic [bil_pkg::IDX_W-1:0] rd_prev_q;
  logic                      first_q;

  logic [bil_pkg::CNT_W-1:0] pos_m1;
  logic [bil_pkg::CNT_W:0]   held_p1;
  logic                      rd_en;
  logic                      wr_en;
  logic [bil_pkg::IDX_W-1:0] wr_addr;
  logic [bil_pkg::VAL_W-1:0] wr_data;
  logic                      shift_wr;

  assign pos_m1  = position_i - bil_pkg::CNT_W'(1);
  assign held_p1 = {1'b0, held_q} + (bil_pkg::CNT_W+1)'(1);

  // Decode and range checks of an incoming transaction
  always_comb begin
    err_d     = 1'b0;
    is_ins_d  = 1'b0;
    is_rem_d  = 1'b0;
    place_d   = 1'b0;
    clr_d     = 1'b0;
    slot_d    = pos_m1[bil_pkg::IDX_W-1:0];
    rd_ptr_d  = pos_m1[bil_pkg::IDX_W-1:0];
    rd_left_d = '0;
    unique case (opcode_i)
      bil_pkg::OP_APPEND: begin
        if (held_q >= Cap) begin
          err_d = 1'b1;
        end else begin
          place_d = 1'b1;
          slot_d  = held_q[bil_pkg::IDX_W-1:0];
        end
      end
      bil_pkg::OP_INSERT: begin
        if (held_q >= Cap || position_i == '0 ||
            {1'b0, position_i} > held_p1) begin
          err_d = 1'b1;
        end else begin
          is_ins_d  = 1'b1;
          place_d   = 1'b1;
          rd_ptr_d  = bil_pkg::IDX_W'(held_q - bil_pkg::CNT_W'(1));
          rd_left_d = held_q - pos_m1;
        end
      end
      bil_pkg::OP_REMOVE_END: begin
        if (held_q == '0) begin
          err_d = 1'b1;
        end else begin
          is_rem_d  = 1'b1;
          rd_ptr_d  = bil_pkg::IDX_W'(held_q - bil_pkg::CNT_W'(1));
          rd_left_d = bil_pkg::CNT_W'(1);
        end
      end
      bil_pkg::OP_REMOVE_AT: begin
        if (position_i == '0 || position_i > held_q) begin
          err_d = 1'b1;
        end else begin
          is_rem_d  = 1'b1;
          rd_left_d = held_q - pos_m1;
        end
      end
      bil_pkg::OP_CLEAR: begin
        clr_d = 1'b1;
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  // Shift engine read and write selection
  assign rd_en    = cmd_i.step && (rd_left_q != '0);
  assign shift_wr = cmd_i.step && rd_vld_q && !(is_rem_q && first_q);
  assign wr_en    = shift_wr || cmd_i.place;
  assign wr_addr  = cmd_i.place ? slot_q :
                    (is_ins_q ? rd_prev_q + bil_pkg::IDX_W'(1)
                              : rd_prev_q - bil_pkg::IDX_W'(1));
  assign wr_data  = cmd_i.place ? val_q : rdata_q;

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  // Payload context and taken value
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q  <= value_in_i;
      slot_q <= slot_d;
    end
    if (cmd_i.step && rd_vld_q && is_rem_q && first_q) begin
      taken_q <= rdata_q;
    end
    if (rd_en) begin
      rd_prev_q <= rd_ptr_q;
    end
  end

  // Next count after the current transaction
  always_comb begin
    held_d = held_q;
    if (clr_q) begin
      held_d = '0;
    end else if (!err_q && place_q) begin
      held_d = held_q + bil_pkg::CNT_W'(1);
    end else if (!err_q && is_rem_q) begin
      held_d = held_q - bil_pkg::CNT_W'(1);
    end
  end

  // Control registers: count, decode flags and shift counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      err_q     <= 1'b0;
      is_ins_q  <= 1'b0;
      is_rem_q  <= 1'b0;
      place_q   <= 1'b0;
      clr_q     <= 1'b0;
      rd_ptr_q  <= '0;
      rd_left_q <= '0;
      rd_vld_q  <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        err_q     <= err_d;
        is_ins_q  <= is_ins_d;
        is_rem_q  <= is_rem_d;
        place_q   <= place_d;
        clr_q     <= clr_d;
        rd_ptr_q  <= rd_ptr_d;
        rd_left_q <= rd_left_d;
        rd_vld_q  <= 1'b0;
        first_q   <= 1'b1;
      end else if (cmd_i.step) begin
        rd_vld_q <= rd_en;
        if (rd_en) begin
          rd_left_q <= rd_left_q - bil_pkg::CNT_W'(1);
          rd_ptr_q  <= is_ins_q ? rd_ptr_q - bil_pkg::IDX_W'(1)
                                : rd_ptr_q + bil_pkg::IDX_W'(1);
        end
        if (rd_vld_q) begin
          first_q <= 1'b0;
        end
      end
      if (cmd_i.finish) begin
        held_q <= held_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o    <= err_q;
      value_out_o <= (is_rem_q && !err_q) ? taken_q : '0;
      count_o     <= held_d;
    end
  end

  assign sts_o.shift_done   = (rd_left_q == '0) && !rd_vld_q;
  assign sts_o.place_needed = place_q && !err_q;

endmodule

`default_nettype wire

[rtl/bil_ctrl.sv]
// ----------------------------------------------------------------------------
// bil_ctrl
// Sequencer: takes one transaction, runs the shift, places the new value for an
// append or insert and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bil_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output bil_pkg::bil_cmd_t       cmd_o,
  input  wire bil_pkg::bil_sts_t  sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.step = 1'b1;
        if (sts_i.shift_done) begin
          state_d = sts_i.place_needed ? ST_PLACE : ST_FINISH;
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/bounded_indexed_list_unit.sv]
// ----------------------------------------------------------------------------
// bounded_indexed_list_unit
// Ordered list of up to 16 signed 32-bit values with append, insert at
// position, remove last, remove at position and clear.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and gives one result with an ok/error
// status, the removed value (zero otherwise) and the count held afterwards.
// Entries live in a memory with a single write port and a registered read,
// so an insert or remove in the middle moves one entry per cycle. A shift
// reads up to 16 entries for a remove and up to 15 for an insert. The block
// is ready for the next transaction as soon as the result is in the output
// register, even while that result waits to be taken; a stalled output only
// holds the block once a new result is ready.
`default_nettype none

module bounded_indexed_list_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [2:0] opcode, [7:3] position, [39:8] value_in
  input  wire logic [bil_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [0] status, [32:1] value_out, [37:33] count, [39:38] zero
  output logic [bil_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);

  bil_pkg::bil_cmd_t cmd;
  bil_pkg::bil_sts_t sts;

  logic                        status;
  logic [bil_pkg::VAL_W-1:0]   value_out;
  logic [bil_pkg::CNT_W-1:0]   count;

  // Sequencer
  bil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Memory, counters and result register
  bil_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (s_axis_tdata_i[2:0]),
    .position_i  (s_axis_tdata_i[7:3]),
    .value_in_i  (s_axis_tdata_i[39:8]),
    .status_o    (status),
    .value_out_o (value_out),
    .count_o     (count)
  );

  assign m_axis_tdata_o = {2'b00, count, value_out, status};

endmodule

`default_nettype wire

[sim/bounded_indexed_list_unit_tb.sv]
// ----------------------------------------------------------------------------
// bounded_indexed_list_unit_tb
// Self-checking stream testbench for the bounded indexed list unit.
// ----------------------------------------------------------------------------
// A queue of list operations is built up front: a directed opening that walks
// the empty, single-entry and full corners, then random traffic that mostly
// keeps positions in range and swings the fill level between empty and full.
// A driver presents the operations and a monitor scores each result against a
// shadow copy of the list, updated as each operation is accepted. Both sides
// throttle in random bursts, the receiver once holds off long enough to back
// up the input, and the sender twice waits for the pipe to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_list_unit_tb;
  import bil_pkg::*;

  // Status codes and the opcodes the block leaves unused
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam int RANDOM_OPS     = 1700;
  localparam int QUIET_TAIL     = 150;   // no throttling once this few remain
  localparam int LONG_HOLD      = 120;   // receiver hold-off, in cycles
  localparam int LONG_HOLD_AT   = 250;   // results seen before that hold-off
  localparam int DRAIN_TIME     = 60;    // settle time after the last result
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic                    drain_first; // wait for all results before sending
    logic signed [VAL_W-1:0] value_in;
    logic [CNT_W-1:0]        position;
    logic [OP_W-1:0]         opcode;
  } list_req_t;

  typedef struct packed {
    logic                    status;
    logic signed [VAL_W-1:0] value_out;
    logic [CNT_W-1:0]        count;
  } list_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  bounded_indexed_list_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  list_req_t  pending_req_q[$];
  list_resp_t expected_resp_q[$];
  int         mismatch_cnt = 0;
  int         results_seen = 0;
  logic       in_taken = 1'b0;  // input transaction at the last rising edge

  // --------------------------------------------------------------------------
  // Shadow list, advanced once per accepted operation
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] shadow_mem[CAPACITY];
  int                      shadow_len = 0;

  function automatic list_resp_t apply_list_op(list_req_t req);
    list_resp_t              rsp;
    logic                    err;
    logic signed [VAL_W-1:0] taken;
    int                      p;
    int                      k;
    p     = int'(req.position);
    err   = 1'b0;
    taken = '0;
    case (req.opcode)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          err = 1'b1;
        end else begin
          shadow_mem[shadow_len] = req.value_in;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (shadow_len >= CAPACITY || p < 1 || p > shadow_len + 1) begin
          err = 1'b1;
        end else begin
          for (k = shadow_len; k >= p; k--) shadow_mem[k] = shadow_mem[k-1];
          shadow_mem[p-1] = req.value_in;
          shadow_len++;
        end
      end
      OP_REMOVE_END, OP_REMOVE_AT: begin
        if (req.opcode == OP_REMOVE_END) p = shadow_len;
        if (p < 1 || p > shadow_len) begin
          err = 1'b1;
        end else begin
          taken = shadow_mem[p-1];
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_mem[k] = shadow_mem[k+1];
          shadow_len--;
        end
      end
      OP_CLEAR: shadow_len = 0;
      default:  err = 1'b1;
    endcase
    rsp.status    = err ? ST_ERR : ST_OK;
    rsp.value_out = err ? '0 : taken;
    rsp.count     = shadow_len[CNT_W-1:0];
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction; gen_len tracks the fill level to aim positions
  // --------------------------------------------------------------------------
  int gen_len = 0;

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(input logic [OP_W-1:0] op, input int pos,
                          input logic signed [VAL_W-1:0] val, input logic drain);
    list_req_t req;
    req.opcode      = op;
    req.position    = pos[CNT_W-1:0];
    req.value_in    = val;
    req.drain_first = drain;
    pending_req_q.push_back(req);
    case (op)
      OP_APPEND: if (gen_len < CAPACITY) gen_len++;
      OP_INSERT: if (gen_len < CAPACITY && pos >= 1 && pos <= gen_len + 1) gen_len++;
      OP_REMOVE_END: if (gen_len > 0) gen_len--;
      OP_REMOVE_AT: if (pos >= 1 && pos <= gen_len) gen_len--;
      OP_CLEAR: gen_len = 0;
      default: ;
    endcase
  endtask

  initial begin
    logic [OP_W-1:0] every_op[8];
    int              grow_bias;
    int              r;
    int              add_pct;
    int              n;
    logic            drain;
    int              wait_cycles;

    every_op = '{OP_APPEND, OP_INSERT, OP_REMOVE_END, OP_REMOVE_AT, OP_CLEAR,
                 OP_RSVD_5, OP_RSVD_6, OP_RSVD_7};

    // Empty list corners and the single-entry case
    queue_op(OP_REMOVE_END, 0, 32'sd0, 1'b0);
    queue_op(OP_REMOVE_AT, 1, 32'sd0, 1'b0);
    queue_op(OP_APPEND, 0, 32'sh8000_0000, 1'b0);
    queue_op(OP_REMOVE_END, 0, 32'sd0, 1'b0);
    queue_op(OP_APPEND, 0, 32'sh7fff_ffff, 1'b0);
    queue_op(OP_REMOVE_AT, 1, 32'sd0, 1'b0);
    // Insert at both ends and outside the valid range, bad removes, reserved ops
    queue_op(OP_INSERT, 1, -32'sd1, 1'b0);
    queue_op(OP_INSERT, 0, 32'sd7, 1'b0);
    queue_op(OP_INSERT, 3, 32'sd7, 1'b0);
    queue_op(OP_INSERT, 2, 32'sd0, 1'b0);
    queue_op(OP_INSERT, 1, 32'sh5555_5555, 1'b0);
    queue_op(OP_REMOVE_AT, 2, 32'sd0, 1'b0);
    queue_op(OP_REMOVE_AT, 0, 32'sd0, 1'b0);
    queue_op(OP_REMOVE_AT, 31, 32'sd0, 1'b0);
    queue_op(OP_RSVD_5, 1, 32'sd1, 1'b0);
    queue_op(OP_RSVD_6, 1, 32'sd1, 1'b0);
    queue_op(OP_RSVD_7, 31, '1, 1'b0);
    queue_op(OP_CLEAR, 0, '1, 1'b0);
    // Fill to capacity, then push against the limit
    while (gen_len < CAPACITY) queue_op(OP_APPEND, 0, pick_value(), 1'b0);
    queue_op(OP_APPEND, 0, 32'sd3, 1'b0);
    queue_op(OP_INSERT, CAPACITY + 1, 32'sd3, 1'b0);
    queue_op(OP_INSERT, 1, 32'sd3, 1'b0);
    queue_op(OP_REMOVE_AT, 1, 32'sd0, 1'b0);
    queue_op(OP_INSERT, CAPACITY, 32'sh7fff_ffff, 1'b0);
    queue_op(OP_REMOVE_AT, CAPACITY, 32'sd0, 1'b0);

    // Random traffic, mostly well-formed, drifting between empty and full
    grow_bias = 1;
    for (n = 0; n < RANDOM_OPS; n++) begin
      drain = (n == 0 || n == RANDOM_OPS / 2);
      if (n % 48 == 0) grow_bias = $urandom_range(0, 2);
      add_pct = (grow_bias == 2) ? 75 : (grow_bias == 0) ? 25 : 50;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 12) begin
        queue_op(every_op[$urandom_range(0, 7)], $urandom_range(0, 31), pick_value(),
                 drain);
      end else if (r < 3) begin
        queue_op(OP_CLEAR, $urandom_range(0, 31), pick_value(), drain);
      end else if (r < add_pct + 3) begin
        if ($urandom_range(0, 1) == 0)
          queue_op(OP_APPEND, $urandom_range(0, 31), pick_value(), drain);
        else
          queue_op(OP_INSERT, $urandom_range(1, gen_len + 1), pick_value(), drain);
      end else begin
        if ($urandom_range(0, 1) == 0)
          queue_op(OP_REMOVE_END, $urandom_range(0, 31), pick_value(), drain);
        else
          queue_op(OP_REMOVE_AT, $urandom_range(1, (gen_len == 0) ? 1 : gen_len),
                   pick_value(), drain);
      end
    end

    // Reset, then wait for the traffic to finish
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    do @(posedge clk_i);
    while (pending_req_q.size() != 0 || s_axis_tvalid_i || expected_resp_q.size() != 0);
    for (wait_cycles = 0; wait_cycles < DRAIN_TIME; wait_cycles++) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_resp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: presents queued operations, with random gaps and drain pauses
  // --------------------------------------------------------------------------
  int   send_gap = 0;
  logic send_throttle = 1'b0;

  always @(negedge clk_i) begin
    logic                 nxt_valid;
    logic [IN_DATA_W-1:0] nxt_data;
    list_req_t            req;
    nxt_valid = s_axis_tvalid_i;
    nxt_data  = s_axis_tdata_i;
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) send_throttle = ~send_throttle;
      if (!s_axis_tvalid_i || in_taken) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (send_throttle && pending_req_q.size() > QUIET_TAIL &&
                     $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 12);
        end else if (pending_req_q.size() != 0 &&
                     !(pending_req_q[0].drain_first && expected_resp_q.size() != 0)) begin
          req       = pending_req_q.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = {req.value_in, req.position, req.opcode};
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= nxt_data;
  end

  // --------------------------------------------------------------------------
  // Receiver backpressure: random bursts plus one long hold-off
  // --------------------------------------------------------------------------
  int   recv_hold = 0;
  logic recv_throttle = 1'b0;
  logic long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) recv_throttle = ~recv_throttle;
      if (recv_hold > 0) begin
        recv_hold--;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        recv_hold      = LONG_HOLD - 1;
      end else if (recv_throttle && pending_req_q.size() > QUIET_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        recv_hold = $urandom_range(0, 12);
      end else begin
        nxt_ready = 1'b1;
      end
    end
    m_axis_tready_i <= nxt_ready;
  end

  // --------------------------------------------------------------------------
  // Monitor: score results, then predict for the operation taken this edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_resp_t got;
    list_resp_t want;
    list_req_t  req;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.status    = m_axis_tdata_o[0];
      got.value_out = m_axis_tdata_o[32:1];
      got.count     = m_axis_tdata_o[37:33];
      results_seen <= results_seen + 1;
      if (expected_resp_q.size() == 0) begin
        $error("unexpected result transaction: status %0d value_out %0d count %0d",
               got.status, got.value_out, got.count);
        mismatch_cnt++;
      end else begin
        want = expected_resp_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_cnt++;
        end
        if (got.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
          mismatch_cnt++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          mismatch_cnt++;
        end
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      req.opcode      = s_axis_tdata_i[2:0];
      req.position    = s_axis_tdata_i[7:3];
      req.value_in    = s_axis_tdata_i[39:8];
      req.drain_first = 1'b0;
      expected_resp_q.push_back(apply_list_op(req));
    end
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either side
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/bil_pkg.sv
rtl/bil_datapath.sv
rtl/bil_ctrl.sv
rtl/bounded_indexed_list_unit.sv
sim/bounded_indexed_list_unit_tb.sv
